### design/eig2_pkg.sv
package eig2_pkg;

    localparam int ENTRY_WIDTH = 16;
    localparam int OUT_WIDTH   = 20;
    localparam int OUT_MIN     = -(2 ** (OUT_WIDTH - 1));
    localparam int OUT_MAX     = (2 ** (OUT_WIDTH - 1)) - 1;

    localparam int TR_W   = ENTRY_WIDTH + 1;
    localparam int PROD_W = 2 * ENTRY_WIDTH + 2;
    localparam int BC_W   = 2 * ENTRY_WIDTH;
    localparam int DISC_W = 2 * ENTRY_WIDTH + 3;
    localparam int MAG_W  = 2 * ENTRY_WIDTH + 2;
    localparam int ROOT_W = ENTRY_WIDTH + 1;
    localparam int REM_W  = ENTRY_WIDTH + 4;
    localparam int SUM_W  = ENTRY_WIDTH + 3;
    localparam int CMP_W  = ((SUM_W > OUT_WIDTH) ? SUM_W : OUT_WIDTH) + 1;
    localparam int N_CELLS = MAG_W / 2;

    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] entry_a;
        logic signed [ENTRY_WIDTH-1:0] entry_b;
        logic signed [ENTRY_WIDTH-1:0] entry_c;
        logic signed [ENTRY_WIDTH-1:0] entry_d;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] first_value;
        logic signed [OUT_WIDTH-1:0] second_value;
        logic                        is_real;
    } t_out_word;

    typedef struct packed {
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic [MAG_W-1:0]         rad;
        logic signed [TR_W-1:0]   tr;
        logic                     is_real;
    } t_sqrt_word;

    function automatic logic signed [OUT_WIDTH-1:0] sat_out(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [CMP_W-1:0] x;
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        x  = CMP_W'(v);
        lo = CMP_W'(OUT_MIN);
        hi = CMP_W'(OUT_MAX);
        if (x < lo) begin
            x = lo;
        end else if (x > hi) begin
            x = hi;
        end
        return OUT_WIDTH'(x);
    endfunction

endpackage

### design/eig2_front.sv
module eig2_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  eig2_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output eig2_pkg::t_sqrt_word  o_word
);
    import eig2_pkg::*;

    // stage 1: difference and trace
    logic                     r_v1;
    logic signed [TR_W-1:0]   r_da;
    logic signed [TR_W-1:0]   r_tr1;
    logic signed [ENTRY_WIDTH-1:0] r_b1;
    logic signed [ENTRY_WIDTH-1:0] r_c1;
    // stage 2: products
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_p;
    logic signed [BC_W-1:0]   r_bc;
    logic signed [TR_W-1:0]   r_tr2;
    // stage 3: discriminant
    logic                     r_v3;
    logic signed [DISC_W-1:0] r_disc;
    logic signed [TR_W-1:0]   r_tr3;
    // stage 4: magnitude
    logic                     r_v4;
    t_sqrt_word               r_out;

    logic rdy1, rdy2, rdy3, rdy4;
    logic signed [PROD_W-1:0] n_p;
    logic signed [BC_W-1:0]   n_bc;
    logic signed [DISC_W-1:0] n_disc;
    logic signed [DISC_W-1:0] neg_disc;

    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign n_p      = PROD_W'(r_da) * PROD_W'(r_da);
    assign n_bc     = BC_W'(r_b1) * BC_W'(r_c1);
    assign n_disc   = DISC_W'(r_p) + (DISC_W'(r_bc) <<< 2);
    assign neg_disc = -r_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_da  <= TR_W'(i_word.entry_a) - TR_W'(i_word.entry_d);
            r_tr1 <= TR_W'(i_word.entry_a) + TR_W'(i_word.entry_d);
            r_b1  <= i_word.entry_b;
            r_c1  <= i_word.entry_c;
        end
        if (rdy2 && r_v1) begin
            r_p   <= n_p;
            r_bc  <= n_bc;
            r_tr2 <= r_tr1;
        end
        if (rdy3 && r_v2) begin
            r_disc <= n_disc;
            r_tr3  <= r_tr2;
        end
        if (rdy4 && r_v3) begin
            r_out.rem     <= '0;
            r_out.root    <= '0;
            r_out.rad     <= r_disc[DISC_W-1] ? MAG_W'(neg_disc) : MAG_W'(r_disc);
            r_out.tr      <= r_tr3;
            r_out.is_real <= !r_disc[DISC_W-1];
        end
    end

    assign o_valid = r_v4;
    assign o_word  = r_out;

endmodule

### design/eig2_sqrt_cell.sv
module eig2_sqrt_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  eig2_pkg::t_sqrt_word  i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output eig2_pkg::t_sqrt_word  o_word
);
    import eig2_pkg::*;

    logic             r_valid;
    t_sqrt_word       r_word;
    t_sqrt_word       n_word;
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    logic             take;

    assign o_ready = !r_valid || i_ready;

    // one root bit: bring down two radicand bits, try root*4+1
    assign cand  = {i_word.rem[REM_W-3:0], i_word.rad[MAG_W-1 -: 2]};
    assign trial = {1'b0, i_word.root, 2'b01};
    assign take  = cand >= trial;

    always_comb begin
        n_word      = i_word;
        n_word.rad  = {i_word.rad[MAG_W-3:0], 2'b00};
        n_word.rem  = take ? (cand - trial) : cand;
        n_word.root = {i_word.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### design/eig2_back.sv
module eig2_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  eig2_pkg::t_sqrt_word  i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output eig2_pkg::t_out_word   o_word
);
    import eig2_pkg::*;

    logic                    r_valid;
    t_out_word               r_word;
    t_out_word               n_word;
    logic signed [SUM_W-1:0] tr_ext;
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] sum_hi;
    logic signed [SUM_W-1:0] sum_lo;

    assign o_ready = !r_valid || i_ready;

    assign tr_ext = SUM_W'(i_word.tr);
    assign s_ext  = $signed(SUM_W'(i_word.root));
    assign sum_hi = tr_ext + s_ext;
    assign sum_lo = tr_ext - s_ext;

    always_comb begin
        n_word.is_real = i_word.is_real;
        if (i_word.is_real) begin
            n_word.first_value  = sat_out(sum_hi >>> 1);
            n_word.second_value = sat_out(sum_lo >>> 1);
        end else begin
            n_word.first_value  = sat_out(tr_ext >>> 1);
            n_word.second_value = sat_out(s_ext >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

### design/eigenvalues_2x2.sv
// Eigenvalues of a 2x2 matrix [a b; c d], entries signed Q8.8.
// Input channel: i_valid / o_ready carry one word with the four entries.
// Output channel: o_valid / i_ready carry one word with first_value and
// second_value (signed Q11.8) and is_real. Real roots come larger first;
// a complex pair comes as real part and nonnegative imaginary part.
// The pipeline has four front stages (difference and trace, the two
// products, discriminant, magnitude), one square-root cell per root bit,
// and the output register.
// Throughput is one word per cycle; every stage is a register with its own
// valid bit, so a new word enters each cycle while the chain keeps moving.
// When the receiver stalls, words pile up into empty stages; o_ready drops
// only once every stage holds a word. The output word holds steady until
// taken. Synchronous reset empties all stages; no word is lost or created
// outside of reset.
module eigenvalues_2x2 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  eig2_pkg::t_in_word   i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output eig2_pkg::t_out_word  o_word
);
    import eig2_pkg::*;

    logic       chain_valid [N_CELLS+1];
    logic       chain_ready [N_CELLS+1];
    t_sqrt_word chain_word  [N_CELLS+1];

    eig2_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_word  (chain_word[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        eig2_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_word  (chain_word[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_word  (chain_word[k+1])
        );
    end

    eig2_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[N_CELLS]),
        .o_ready (chain_ready[N_CELLS]),
        .i_word  (chain_word[N_CELLS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

endmodule

### design/eig2_checker.sv
module eig2_port_checks (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input eig2_pkg::t_in_word   i_word,
    input logic                 o_valid,
    input logic                 i_ready,
    input eig2_pkg::t_out_word  o_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word shown right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("output word dropped while stalled");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_word))
        else $error("output word changed while stalled");

    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.is_real) |-> (o_word.first_value >= o_word.second_value))
        else $error("real roots out of order");

    a_imag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.is_real) |-> !o_word.second_value[$bits(o_word.second_value)-1])
        else $error("negative imaginary part");

endmodule

bind eigenvalues_2x2 eig2_port_checks u_eig2_port_checks (.*);

### bench/eig2_checker.sv
module eig2_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  eig2_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  eig2_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);
    import eig2_pkg::*;

    t_out_word pending_eigs[$];
    t_out_word want;
    int        fail_total = 0;

    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int k = 24; k >= 0; k--) begin
            t = r | (longint'(1) << k);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] clamp_q11(longint v);
        if (v < OUT_MIN) begin
            v = OUT_MIN;
        end else if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        return OUT_WIDTH'(v);
    endfunction

    function automatic t_out_word eig_predict(t_in_word w);
        longint    a;
        longint    b;
        longint    c;
        longint    d;
        longint    tr;
        longint    disc;
        longint    root;
        t_out_word r;
        a    = w.entry_a;
        b    = w.entry_b;
        c    = w.entry_c;
        d    = w.entry_d;
        tr   = a + d;
        disc = (a - d) * (a - d) + 4 * b * c;
        if (disc >= 0) begin
            root           = root_floor(disc);
            r.first_value  = clamp_q11((tr + root) >>> 1);
            r.second_value = clamp_q11((tr - root) >>> 1);
            r.is_real      = 1'b1;
        end else begin
            root           = root_floor(-disc);
            r.first_value  = clamp_q11(tr >>> 1);
            r.second_value = clamp_q11(root >>> 1);
            r.is_real      = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_eigs.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_eigs.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("unexpected word: first %0d second %0d real %0b",
                                 i_out_word.first_value, i_out_word.second_value,
                                 i_out_word.is_real);
                    end
                    fail_total++;
                end else begin
                    want = pending_eigs.pop_front();
                    if (i_out_word.first_value !== want.first_value ||
                        i_out_word.second_value !== want.second_value ||
                        i_out_word.is_real !== want.is_real) begin
                        if (fail_total < 10) begin
                            $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     want.first_value, want.second_value, want.is_real,
                                     i_out_word.first_value, i_out_word.second_value,
                                     i_out_word.is_real);
                        end
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_eigs.insert(pending_eigs.size(), eig_predict(i_in_word));
            end
            o_pending <= pending_eigs.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

### bench/tb_eigenvalues_2x2.sv
module tb_eigenvalues_2x2;

    import eig2_pkg::*;

    typedef enum logic [1:0] {PACE_MIXED, PACE_FULL_SPEED, PACE_FLAT_OUT} t_pace;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_word  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_word;
    int        fail_count;
    int        words_waiting;
    t_pace     pace = PACE_MIXED;

    always #5 i_clk = ~i_clk;

    eigenvalues_2x2 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    eig2_checker eig_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_word),
        .o_fail_count (fail_count),
        .o_pending    (words_waiting)
    );

    function automatic t_in_word matrix(
        input logic signed [ENTRY_WIDTH-1:0] a,
        input logic signed [ENTRY_WIDTH-1:0] b,
        input logic signed [ENTRY_WIDTH-1:0] c,
        input logic signed [ENTRY_WIDTH-1:0] d
    );
        t_in_word w;
        w.entry_a = a;
        w.entry_b = b;
        w.entry_c = c;
        w.entry_d = d;
        return w;
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] small_entry();
        return ENTRY_WIDTH'(int'($urandom_range(0, 16)) - 8);
    endfunction

    function automatic logic signed [ENTRY_WIDTH-1:0] rand_entry();
        int v;
        case ($urandom_range(0, 7))
            0: v = 32767;
            1: v = -32768;
            2: v = small_entry();
            3, 4: v = int'($urandom_range(0, 4096)) - 2048;
            default: v = $urandom;
        endcase
        return ENTRY_WIDTH'(v);
    endfunction

    function automatic t_in_word rand_matrix();
        t_in_word w;
        w = matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry());
        case ($urandom_range(0, 7))
            3: begin
                if ($urandom_range(0, 1) != 0) begin
                    w.entry_b = '0;
                end else begin
                    w.entry_c = '0;
                end
                if ($urandom_range(0, 3) == 0) begin
                    w.entry_d = w.entry_a;
                end
            end
            4: w.entry_c = w.entry_b;
            5: begin
                w.entry_d = w.entry_a + ENTRY_WIDTH'(int'($urandom_range(0, 6)) - 3);
                if (w.entry_b[ENTRY_WIDTH-1] == w.entry_c[ENTRY_WIDTH-1]) begin
                    w.entry_c = ~w.entry_c;
                end
            end
            6: w = {$urandom, $urandom};
            7: w = matrix(small_entry(), small_entry(), small_entry(), small_entry());
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = (pace == PACE_MIXED) ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0) @(posedge i_clk);
    endtask

    initial begin : drain
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = (pace == PACE_FULL_SPEED) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(matrix(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_word(matrix(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_word(matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_word(matrix(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000));
        send_word(matrix(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_word(matrix(16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0000));
        send_word(matrix(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_word(matrix(16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100));
        send_word(matrix(16'sh0300, 16'sh0100, 16'shFF00, 16'sh0100));
        send_word(matrix(16'shFFFD, 16'sh0000, 16'sh0000, 16'sh0000));
        send_word(matrix(16'shFFFE, 16'sh0000, 16'sh0000, 16'shFFFF));
        send_word(matrix(16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0000));
        send_word(matrix(16'sh0500, 16'sh0001, 16'shFFFF, 16'sh0000));
        send_word(matrix(16'sh0000, 16'shFF00, 16'sh0100, 16'sh0000));
        send_word(matrix(16'sh7FFF, 16'sh1234, 16'sh0000, 16'sh8000));
        send_word(matrix(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF));
        send_word(matrix(16'sh0001, 16'sh0001, 16'shFFFF, 16'sh0001));
        send_word(matrix(16'sh0000, 16'sh8000, 16'sh8000, 16'sh0000));

        for (int n = 0; n < 950; n++) begin
            if (n < 300) begin
                pace <= PACE_MIXED;
            end else if (n < 400) begin
                pace <= PACE_FULL_SPEED;
            end else if (n < 550) begin
                pace <= PACE_FLAT_OUT;
            end else begin
                pace <= PACE_MIXED;
            end
            if (n == 250 || n == 700) begin
                settle();
            end
            send_word(rand_matrix());
        end

        settle();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && words_waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
